>>> rtl/core/abs_pkg.sv
// Shared types and constants for the Arakawa bracket stencil.
`default_nettype none

package abs_pkg;

    localparam int DATA_W  = 32;
    localparam int MAX_Z   = 1024;
    localparam int CNT_W   = $clog2(MAX_Z);
    localparam int ZPOS_W  = 10;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = 72;
    localparam int ACC_W   = 104;
    localparam int FRAC_W  = 48;

    // One z-slice: f and g at rows x-1, x, x+1.
    typedef struct packed {
        logic signed [DATA_W-1:0] fl;
        logic signed [DATA_W-1:0] fm;
        logic signed [DATA_W-1:0] fr;
        logic signed [DATA_W-1:0] gl;
        logic signed [DATA_W-1:0] gm;
        logic signed [DATA_W-1:0] gr;
    } slice_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pt_status_t;

endpackage

`default_nettype wire

>>> rtl/core/abs_point_unit.sv
// Point evaluator: ten stencil products and the scale multiply on one shared multiplier.
`default_nettype none

module abs_point_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire abs_pkg::slice_t             slice_a,
    input  wire abs_pkg::slice_t             slice_b,
    input  wire abs_pkg::slice_t             slice_c,
    input  wire logic [abs_pkg::DATA_W-1:0]  scale,
    output abs_pkg::pt_status_t              status,
    output logic signed [abs_pkg::DATA_W-1:0] result
);
    import abs_pkg::*;

    localparam logic [4:0] STEP_TERM_LAST   = 5'd9;
    localparam logic [4:0] STEP_SCALE_FIRST = 5'd12;
    localparam logic [4:0] STEP_SCALE_LAST  = 5'd14;
    localparam logic [4:0] STEP_END         = 5'd16;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_32 = 2'd1;
    localparam logic [1:0] SH_64 = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] x0;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] y0;
        logic                     neg;
    } term_t;

    // term = +/- (x1 - x0) * (y1 - y0)
    function automatic term_t pick_term(input logic [3:0] idx, input slice_t a,
                                        input slice_t b, input slice_t c);
        term_t t;
        t = '0;
        unique case (idx)
            4'd0: t = '{x1: c.fm, x0: a.fm, y1: b.gr, y0: b.gl, neg: 1'b0};
            4'd1: t = '{x1: b.fr, x0: b.fl, y1: c.gm, y0: a.gm, neg: 1'b1};
            4'd2: t = '{x1: b.gr, x0: '0,   y1: c.fr, y0: a.fr, neg: 1'b0};
            4'd3: t = '{x1: b.gl, x0: '0,   y1: c.fl, y0: a.fl, neg: 1'b1};
            4'd4: t = '{x1: c.gm, x0: '0,   y1: c.fr, y0: c.fl, neg: 1'b1};
            4'd5: t = '{x1: a.gm, x0: '0,   y1: a.fr, y0: a.fl, neg: 1'b0};
            4'd6: t = '{x1: c.gr, x0: '0,   y1: c.fm, y0: b.fr, neg: 1'b0};
            4'd7: t = '{x1: a.gl, x0: '0,   y1: b.fl, y0: a.fm, neg: 1'b1};
            4'd8: t = '{x1: c.gl, x0: '0,   y1: c.fm, y0: b.fl, neg: 1'b1};
            4'd9: t = '{x1: a.gr, x0: '0,   y1: b.fr, y0: a.fm, neg: 1'b0};
            default: t = '0;
        endcase
        return t;
    endfunction

    logic [4:0] step_reg, step_next;
    logic       run_reg, run_next;
    logic       done_reg, done_next;

    logic                    op_vld_reg, op_vld_next;
    logic                    op_neg_reg, op_neg_next;
    logic                    op_scl_reg, op_scl_next;
    logic [1:0]              op_sh_reg, op_sh_next;
    logic signed [MUL_W-1:0] op_a_reg, op_a_next;
    logic signed [MUL_W-1:0] op_b_reg, op_b_next;

    logic                     mul_vld_reg;
    logic                     mul_neg_reg;
    logic                     mul_scl_reg;
    logic [1:0]               mul_sh_reg;
    logic signed [PROD_W-1:0] mul_reg;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;

    term_t            term;
    logic [SUM_W-1:0] mag;
    logic [1:0]       chunk;
    logic [DATA_W-1:0] chunk_val;
    logic [2*DATA_W-1:0] prod_u;
    logic [ACC_W-1:0] prod_sh;
    logic [ACC_W-FRAC_W-1:0] q;

    assign term  = pick_term(step_reg[3:0], slice_a, slice_b, slice_c);
    assign mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign chunk = 2'(step_reg - STEP_SCALE_FIRST);

    always_comb
    begin
        unique case (chunk)
            SH_0:    chunk_val = mag[DATA_W-1:0];
            SH_32:   chunk_val = mag[2*DATA_W-1:DATA_W];
            SH_64:   chunk_val = DATA_W'(mag[SUM_W-1:2*DATA_W]);
            default: chunk_val = '0;
        endcase
    end

    assign prod_u = mul_reg[2*DATA_W-1:0];

    always_comb
    begin
        unique case (mul_sh_reg)
            SH_0:    prod_sh = ACC_W'(prod_u);
            SH_32:   prod_sh = ACC_W'({prod_u, {DATA_W{1'b0}}});
            SH_64:   prod_sh = {prod_u[ACC_W-2*DATA_W-1:0], {(2*DATA_W){1'b0}}};
            default: prod_sh = '0;
        endcase
    end

    // sequencer and operand issue
    always_comb
    begin
        step_next   = step_reg;
        run_next    = run_reg;
        done_next   = done_reg;
        op_vld_next = 1'b0;
        op_neg_next = 1'b0;
        op_scl_next = 1'b0;
        op_sh_next  = SH_0;
        op_a_next   = op_a_reg;
        op_b_next   = op_b_reg;

        if (start)
        begin
            step_next = '0;
            run_next  = 1'b1;
            done_next = 1'b0;
        end
        else if (run_reg)
        begin
            step_next = step_reg + 5'd1;
            if (step_reg <= STEP_TERM_LAST)
            begin
                op_vld_next = 1'b1;
                op_neg_next = term.neg;
                op_a_next   = {{2{term.x1[DATA_W-1]}}, term.x1}
                            - {{2{term.x0[DATA_W-1]}}, term.x0};
                op_b_next   = {{2{term.y1[DATA_W-1]}}, term.y1}
                            - {{2{term.y0[DATA_W-1]}}, term.y0};
            end
            else if (step_reg >= STEP_SCALE_FIRST && step_reg <= STEP_SCALE_LAST)
            begin
                op_vld_next = 1'b1;
                op_scl_next = 1'b1;
                op_sh_next  = chunk;
                op_a_next   = {2'b00, chunk_val};
                op_b_next   = {2'b00, scale};
            end
            if (step_reg == STEP_END)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        acc_next = acc_reg;
        if (start)
        begin
            sum_next = '0;
            // rounding half, added up front
            acc_next = ACC_W'(1) << (FRAC_W - 1);
        end
        else if (mul_vld_reg && !mul_scl_reg)
        begin
            sum_next = mul_neg_reg ? sum_reg - SUM_W'(mul_reg) : sum_reg + SUM_W'(mul_reg);
        end
        else if (mul_vld_reg)
        begin
            acc_next = acc_reg + prod_sh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            run_reg     <= 1'b0;
            done_reg    <= 1'b0;
            op_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            run_reg     <= run_next;
            done_reg    <= done_next;
            op_vld_reg  <= op_vld_next;
            mul_vld_reg <= op_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_neg_reg  <= op_neg_next;
        op_scl_reg  <= op_scl_next;
        op_sh_reg   <= op_sh_next;
        op_a_reg    <= op_a_next;
        op_b_reg    <= op_b_next;
        mul_neg_reg <= op_neg_reg;
        mul_scl_reg <= op_scl_reg;
        mul_sh_reg  <= op_sh_reg;
        mul_reg     <= op_a_reg * op_b_reg;
        sum_reg     <= sum_next;
        acc_reg     <= acc_next;
    end

    // round already applied; saturate on the magnitude
    assign q = acc_reg[ACC_W-1:FRAC_W];

    always_comb
    begin
        if (sum_reg[SUM_W-1])
        begin
            if (q >= (ACC_W-FRAC_W)'(64'h8000_0000))
                result = {1'b1, {(DATA_W-1){1'b0}}};
            else
                result = DATA_W'(-q);
        end
        else
        begin
            if (q > (ACC_W-FRAC_W)'(64'h7FFF_FFFF))
                result = {1'b0, {(DATA_W-1){1'b1}}};
            else
                result = DATA_W'(q);
        end
    end

    assign status = '{busy: run_reg, done: done_reg};

endmodule

`default_nettype wire

>>> rtl/core/arakawa_bracket_stencil.sv
// Arakawa Poisson bracket along one periodic z-row, one slice per request.
// Input channel: in_valid/in_ready carry one z-slice (f and g on rows x-1, x,
// x+1, the row spacing scale and a last-slice flag). The scale is taken from
// the first slice of each row only.
// Output channel: out_valid/out_ready carry one bracket point per request
// with its z index; last_result marks the wrapped point z = 0.
// The first two slices of a row produce nothing and are taken back to back.
// Every later slice produces one point; the last slice produces three
// (z = k-1, z = k, then z = 0). A last flag on slice 0 or 1 emits nothing.
// Each point runs through a start state, 17 point-unit steps in which the
// ten stencil products and three scale partial products pass through one
// 34x34 multiplier, a state that waits for done and one that loads the
// output register. The next slice is taken once the last point of the
// current slice has been loaded into the output register.
// in_ready is high only while no slice is in work; the output register lets
// a new slice in while the last point still waits to be taken.
// A stalled receiver holds the finished point in the point unit until the
// output register frees up.
// Reset clears the row position and empties the output.
`default_nettype none

module arakawa_bracket_stencil (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [31:0]           f_left,
    input  wire logic signed [31:0]           f_mid,
    input  wire logic signed [31:0]           f_right,
    input  wire logic signed [31:0]           g_left,
    input  wire logic signed [31:0]           g_mid,
    input  wire logic signed [31:0]           g_right,
    input  wire logic [31:0]                  spacing_scale,
    input  wire logic                         last_in_row,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [31:0]                bracket_value,
    output logic [abs_pkg::ZPOS_W-1:0]        z_position,
    output logic                              last_result
);
    import abs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_CALC,
        S_PUSH
    } state_t;

    localparam logic [1:0] PT_MID   = 2'd0;
    localparam logic [1:0] PT_END   = 2'd1;
    localparam logic [1:0] PT_WRAP  = 2'd2;

    state_t            state_reg, state_next;
    logic [1:0]        pt_idx_reg, pt_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [ZPOS_W-1:0] zpos_reg, zpos_next;
    logic              lastres_reg, lastres_next;

    slice_t            first_reg, second_reg, older_reg, prev_reg, cur_reg;
    logic [DATA_W-1:0] scale_reg;

    slice_t            in_slice;
    slice_t            sel_a, sel_b, sel_c;
    logic              accept;
    logic              out_free;
    logic              shift_in, shift_cur;
    logic              pt_start;
    pt_status_t        pt_status;
    logic signed [DATA_W-1:0] pt_result;
    logic [ZPOS_W-1:0] z_sel;

    function automatic logic [CNT_W-1:0] next_count(input logic [CNT_W-1:0] k,
                                                    input logic last);
        logic [CNT_W:0] k1;
        k1 = {1'b0, k} + (CNT_W+1)'(1);
        if (last)
            return '0;
        else if (int'(k1) < MAX_Z)
            return k1[CNT_W-1:0];
        else
            return k;
    endfunction

    assign in_slice = '{fl: f_left, fm: f_mid, fr: f_right,
                        gl: g_left, gm: g_mid, gr: g_right};
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign pt_start = (state_reg == S_START);

    always_comb
    begin
        unique case (pt_idx_reg)
            PT_MID:
            begin
                sel_a = older_reg;
                sel_b = prev_reg;
                sel_c = cur_reg;
                z_sel = ZPOS_W'(count_reg - CNT_W'(1));
            end
            PT_END:
            begin
                sel_a = prev_reg;
                sel_b = cur_reg;
                sel_c = first_reg;
                z_sel = ZPOS_W'(count_reg);
            end
            PT_WRAP:
            begin
                sel_a = cur_reg;
                sel_b = first_reg;
                sel_c = second_reg;
                z_sel = '0;
            end
            default:
            begin
                sel_a = cur_reg;
                sel_b = cur_reg;
                sel_c = cur_reg;
                z_sel = '0;
            end
        endcase
    end

    abs_point_unit u_point (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pt_start),
        .slice_a (sel_a),
        .slice_b (sel_b),
        .slice_c (sel_c),
        .scale   (scale_reg),
        .status  (pt_status),
        .result  (pt_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        pt_idx_next    = pt_idx_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        zpos_next      = zpos_reg;
        lastres_next   = lastres_reg;
        shift_in       = 1'b0;
        shift_cur      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        shift_in   = 1'b1;
                        count_next = next_count(count_reg, last_in_row);
                    end
                    else
                    begin
                        last_next   = last_in_row;
                        pt_idx_next = PT_MID;
                        state_next  = S_START;
                    end
                end
            end
            S_START:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (pt_status.done)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = pt_result;
                    zpos_next      = z_sel;
                    lastres_next   = (pt_idx_reg == PT_WRAP);
                    if (!last_reg || pt_idx_reg == PT_WRAP)
                    begin
                        shift_cur  = 1'b1;
                        count_next = next_count(count_reg, last_reg);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pt_idx_next = pt_idx_reg + 2'd1;
                        state_next  = S_START;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pt_idx_reg    <= PT_MID;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            zpos_reg      <= '0;
            lastres_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pt_idx_reg    <= pt_idx_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
            zpos_reg      <= zpos_next;
            lastres_reg   <= lastres_next;
        end
    end

    // slice history
    always_ff @(posedge clk)
    begin
        if (accept && count_reg == CNT_W'(0))
        begin
            first_reg <= in_slice;
            scale_reg <= spacing_scale;
        end
        if (accept && count_reg == CNT_W'(1))
            second_reg <= in_slice;
        if (accept && count_reg >= CNT_W'(2))
            cur_reg <= in_slice;
        if (shift_in)
        begin
            older_reg <= prev_reg;
            prev_reg  <= in_slice;
        end
        else if (shift_cur)
        begin
            older_reg <= prev_reg;
            prev_reg  <= cur_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bracket_value = value_reg;
    assign z_position    = zpos_reg;
    assign last_result   = lastres_reg;

`ifndef SYNTHESIS
    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pt_status.busy)
        else $error("point unit busy while idle");

    a_pt_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> pt_idx_reg != 2'd3)
        else $error("point index out of range");

    a_wrap_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_result |-> z_position == '0)
        else $error("final result not at z zero");

    a_short_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && count_reg < CNT_W'(2) |=> state_reg == S_IDLE && !out_valid_reg
            || state_reg == S_IDLE && $past(out_valid_reg))
        else $error("early slice started a point");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for arakawa_bracket_stencil: random row streams checked against a bit-exact predictor.
`timescale 1ns / 100ps

module tb;

    import abs_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        slice_t      s;
        logic [31:0] scale;
        logic        last;
    } slice_req_t;

    typedef struct {
        logic signed [31:0] value;
        logic [9:0]         z;
        logic               last;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] f_left = '0;
    logic signed [31:0] f_mid = '0;
    logic signed [31:0] f_right = '0;
    logic signed [31:0] g_left = '0;
    logic signed [31:0] g_mid = '0;
    logic signed [31:0] g_right = '0;
    logic [31:0]        spacing_scale = '0;
    logic               last_in_row = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] bracket_value;
    logic [9:0]         z_position;
    logic               last_result;

    arakawa_bracket_stencil u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .f_left        (f_left),
        .f_mid         (f_mid),
        .f_right       (f_right),
        .g_left        (g_left),
        .g_mid         (g_mid),
        .g_right       (g_right),
        .spacing_scale (spacing_scale),
        .last_in_row   (last_in_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bracket_value (bracket_value),
        .z_position    (z_position),
        .last_result   (last_result)
    );

    always #2 clk = ~clk;

    slice_req_t pending_slices[$];
    point_t     expected_points[$];

    int n_items = 32'h7FFF_FFFF;
    int slices_taken = 0;
    int rows_done = 0;
    int points_checked = 0;
    int errors = 0;

    // predictor copy of the row window
    slice_t      row_first = '0;
    slice_t      row_second = '0;
    slice_t      row_older = '0;
    slice_t      row_prev = '0;
    int          row_idx = 0;
    logic [31:0] row_scl = '0;

    function automatic logic [31:0] bracket_point(input slice_t sa, input slice_t sb,
                                                  input slice_t sc, input logic [31:0] scale);
        wide_t        a[6];
        wide_t        b[6];
        wide_t        c[6];
        wide_t        sum;
        logic         neg;
        logic [127:0] mag;
        logic [127:0] prod;
        logic [63:0]  q;
        a[0] = $signed(sa.fl); a[1] = $signed(sa.fm); a[2] = $signed(sa.fr);
        a[3] = $signed(sa.gl); a[4] = $signed(sa.gm); a[5] = $signed(sa.gr);
        b[0] = $signed(sb.fl); b[1] = $signed(sb.fm); b[2] = $signed(sb.fr);
        b[3] = $signed(sb.gl); b[4] = $signed(sb.gm); b[5] = $signed(sb.gr);
        c[0] = $signed(sc.fl); c[1] = $signed(sc.fm); c[2] = $signed(sc.fr);
        c[3] = $signed(sc.gl); c[4] = $signed(sc.gm); c[5] = $signed(sc.gr);
        // four times Jpp + Jpx + Jxp, exact in Q32.32
        sum = (c[1] - a[1]) * (b[5] - b[3]) - (b[2] - b[0]) * (c[4] - a[4])
            + b[5] * (c[2] - a[2]) - b[3] * (c[0] - a[0])
            - c[4] * (c[2] - c[0]) + a[4] * (a[2] - a[0])
            + c[5] * (c[1] - b[2]) - a[3] * (b[0] - a[1])
            - c[3] * (c[1] - b[0]) + a[5] * (b[2] - a[1]);
        neg  = sum[127];
        mag  = neg ? -sum : sum;
        // Q48.48, round half away from zero on the magnitude
        prod = mag * scale + (128'd1 << 47);
        if (prod[127:112] != '0)
            q = '1;
        else
            q = prod[111:48];
        if (neg)
        begin
            if (q >= 64'h8000_0000)
                return 32'h8000_0000;
            return 32'd0 - q[31:0];
        end
        if (q > 64'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic point_t make_point(input logic [31:0] v, input int z, input logic last);
        point_t p;
        p.value = v;
        p.z     = 10'(z);
        p.last  = last;
        return p;
    endfunction

    task automatic take_slice(input slice_req_t req);
        int k;
        k = row_idx;
        if (k == 0)
        begin
            row_scl   = req.scale;
            row_first = req.s;
        end
        else if (k == 1)
            row_second = req.s;
        if (k >= 2)
        begin
            expected_points.push_back(make_point(
                bracket_point(row_older, row_prev, req.s, row_scl), k - 1, 1'b0));
            if (req.last)
            begin
                expected_points.push_back(make_point(
                    bracket_point(row_prev, req.s, row_first, row_scl), k, 1'b0));
                expected_points.push_back(make_point(
                    bracket_point(req.s, row_first, row_second, row_scl), 0, 1'b1));
            end
        end
        row_older = row_prev;
        row_prev  = req.s;
        if (req.last)
        begin
            row_idx = 0;
            rows_done++;
        end
        else if (k + 1 < MAX_Z)
            row_idx = k + 1;
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: return r;
            3, 4, 5, 6: return {{14{r[17]}}, r[17:0]};
            7: return 32'h7FFF_FFFF;
            8: return 32'h8000_0000;
            default: return '0;
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            6: return '0;
            7: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 32'h0003_FFFF);
        endcase
    endfunction

    function automatic slice_t rand_slice();
        slice_t s;
        s.fl = rand_word(); s.fm = rand_word(); s.fr = rand_word();
        s.gl = rand_word(); s.gm = rand_word(); s.gr = rand_word();
        return s;
    endfunction

    function automatic slice_t flat_slice(input logic [31:0] v);
        slice_t s;
        s.fl = v; s.fm = v; s.fr = v; s.gl = v; s.gm = v; s.gr = v;
        return s;
    endfunction

    task automatic add_slice(input slice_t s, input logic [31:0] scale, input logic last);
        slice_req_t req;
        req.s     = s;
        req.scale = scale;
        req.last  = last;
        pending_slices.push_back(req);
    endtask

    task automatic add_row(input int len);
        for (int i = 0; i < len; i++)
            add_slice(rand_slice(), rand_scale(), i == len - 1);
    endtask

    // single point term c.gr * c.fm, scaled to exactly one half LSB
    task automatic add_tie_row(input logic signed [31:0] fm);
        slice_t s;
        s    = '0;
        add_slice(s, 32'h8000_0000, 1'b0);
        add_slice(s, 32'h0000_0001, 1'b0);
        s.gr = 32'sd1;
        s.fm = fm;
        add_slice(s, 32'h0000_0002, 1'b1);
    endtask

    task automatic build_stimulus();
        slice_t mix;
        int     target;
        mix.fl = 32'h7FFF_FFFF; mix.fm = 32'h8000_0000; mix.fr = 32'h7FFF_FFFF;
        mix.gl = 32'h8000_0000; mix.gm = 32'h7FFF_FFFF; mix.gr = 32'h8000_0000;
        // rows too short to emit anything
        add_slice(flat_slice(32'h7FFF_FFFF), 32'hFFFF_FFFF, 1'b1);
        add_slice(flat_slice(32'h8000_0000), 32'h0000_0000, 1'b0);
        add_slice(flat_slice(32'h8000_0000), 32'hFFFF_FFFF, 1'b1);
        // extremes with the largest scale: saturation both ways
        add_slice(flat_slice(32'h7FFF_FFFF), 32'hFFFF_FFFF, 1'b0);
        add_slice(flat_slice(32'h8000_0000), 32'h0000_0000, 1'b0);
        add_slice(mix, 32'h1234_5678, 1'b1);
        add_slice(mix, 32'hFFFF_FFFF, 1'b0);
        add_slice(flat_slice(32'h7FFF_FFFF), 32'h0, 1'b0);
        add_slice(~mix, 32'h0, 1'b1);
        add_tie_row(32'sd65536);
        add_tie_row(-32'sd65536);
        // zero scale, then a row whose later scales differ from the first
        add_slice(rand_slice(), 32'h0, 1'b0);
        add_slice(rand_slice(), 32'hFFFF_FFFF, 1'b0);
        add_slice(rand_slice(), 32'hFFFF_FFFF, 1'b0);
        add_slice(rand_slice(), 32'hFFFF_FFFF, 1'b1);
        add_slice(flat_slice(32'h0001_0000), 32'h0000_1555, 1'b0);
        add_slice(mix >> 12, 32'hFFFF_FFFF, 1'b0);
        add_slice(flat_slice(32'hFFFF_0000), 32'h0, 1'b0);
        add_slice(rand_slice(), 32'hABCD_0000, 1'b0);
        add_slice(rand_slice(), 32'h0, 1'b1);
        target = pending_slices.size() + 480;
        while (pending_slices.size() < target)
        begin
            case ($urandom_range(0, 9))
                0: add_row($urandom_range(1, 2));
                1: add_row($urandom_range(11, 40));
                default: add_row($urandom_range(3, 10));
            endcase
        end
    endtask

    // sender
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            f_left        <= '0;
            f_mid         <= '0;
            f_right       <= '0;
            g_left        <= '0;
            g_mid         <= '0;
            g_right       <= '0;
            spacing_scale <= '0;
            last_in_row   <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                take_slice(pending_slices.pop_front());
                slices_taken++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_slices.size() != 0 && slices_taken + 60 < n_items
                         && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end
                else if (pending_slices.size() != 0)
                begin
                    in_valid      <= 1'b1;
                    f_left        <= pending_slices[0].s.fl;
                    f_mid         <= pending_slices[0].s.fm;
                    f_right       <= pending_slices[0].s.fr;
                    g_left        <= pending_slices[0].s.gl;
                    g_mid         <= pending_slices[0].s.gm;
                    g_right       <= pending_slices[0].s.gr;
                    spacing_scale <= pending_slices[0].scale;
                    last_in_row   <= pending_slices[0].last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    int   stall_left = 0;
    logic long_hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    errors++;
                    $error("unexpected point: value %0d z %0d last %0b",
                           bracket_value, z_position, last_result);
                end
                else
                begin
                    point_t exp_pt;
                    exp_pt = expected_points.pop_front();
                    if (bracket_value !== exp_pt.value)
                    begin
                        errors++;
                        $error("bracket_value: expected %0d, got %0d",
                               exp_pt.value, bracket_value);
                    end
                    if (z_position !== exp_pt.z)
                    begin
                        errors++;
                        $error("z_position: expected %0d, got %0d", exp_pt.z, z_position);
                    end
                    if (last_result !== exp_pt.last)
                    begin
                        errors++;
                        $error("last_result: expected %0b, got %0b",
                               exp_pt.last, last_result);
                    end
                end
                points_checked++;
            end
            // one long hold-off so the block backs up into its input
            if (!long_hold_done && points_checked >= 80)
            begin
                long_hold_done = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (slices_taken + 60 < n_items && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        build_stimulus();
        n_items = pending_slices.size();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (slices_taken < n_items || expected_points.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("run covered %0d slices in %0d rows, with short rows, extremes and ties;",
                 slices_taken, rows_done);
        $display("%0d bracket points compared, %0d field mismatches", points_checked, errors);
        if (errors == 0)
            $display("** arakawa_bracket_stencil: PASSED **");
        else
            $display("** arakawa_bracket_stencil: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d of %0d slices taken, %0d points outstanding",
                 slices_taken, n_items, expected_points.size());
        $display("** arakawa_bracket_stencil: FAILED **");
        $finish;
    end

endmodule

>>> arakawa_bracket_stencil.f
rtl/core/abs_pkg.sv
rtl/core/abs_point_unit.sv
rtl/core/arakawa_bracket_stencil.sv
tb/sv/tb.sv
